/* hw/rtl/ipip_pkg.sv */
package ipip_pkg;

  // fixed header constants
  localparam logic [3:0]  IP_V4      = 4'd4;
  localparam logic [3:0]  HDR_WORDS  = 4'd5;
  localparam logic [7:0]  PROTO_IPIP = 8'd4;
  localparam logic [15:0] HDR_BYTES  = 16'd20;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_ADDR  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REMOTE_ADDR = 1'b1;

  // drop reasons, in check order
  typedef enum logic [2:0] {
    VERDICT_FORWARD   = 3'd0,
    VERDICT_NO_REMOTE = 3'd1,
    VERDICT_NOT_IPV4  = 3'd2,
    VERDICT_LOOP      = 3'd3,
    VERDICT_INBOUND   = 3'd4
  } verdict_t;

  // outer header fields that feed the checksum
  typedef struct packed {
    logic [7:0]  tos;
    logic [15:0] length;
    logic [15:0] ident;
    logic [7:0]  ttl;
    logic [31:0] source;
    logic [31:0] dest;
  } hdr_fields_t;

endpackage

/* hw/rtl/ipip_csum.sv */
module ipip_csum
  import ipip_pkg::*;
(
  input  hdr_fields_t hdr,
  output logic [15:0] checksum
);

  logic [18:0] sum;
  logic [16:0] fold1;
  logic [16:0] fold2;

  // sum of the eight nonzero header words
  always_comb begin
    sum = {3'd0, IP_V4, HDR_WORDS, hdr.tos}
        + {3'd0, hdr.length}
        + {3'd0, hdr.ident}
        + {3'd0, hdr.ttl, PROTO_IPIP}
        + {3'd0, hdr.source[31:16]}
        + {3'd0, hdr.source[15:0]}
        + {3'd0, hdr.dest[31:16]}
        + {3'd0, hdr.dest[15:0]};
  end

  // end-around carry, twice, then complement
  assign fold1    = {1'b0, sum[15:0]} + {14'd0, sum[18:16]};
  assign fold2    = {1'b0, fold1[15:0]} + {16'd0, fold1[16]};
  assign checksum = ~fold2[15:0];

endmodule

/* hw/rtl/ipip_outer_header_builder.sv */
// IP-in-IP outer header builder.
// Input: a transaction is taken at each rising edge with start high and busy
// low; busy is always low, so one header can be taken every cycle. The fields
// in_inner_* carry the inner IPv4 header and the inner packet length.
// Output: for every input transaction exactly one result is shown for one cycle
// with out_strobe high. out_verdict is forward (0) or the first failing check:
// no remote address, not IPv4, routing loop, inbound. Dropped results carry
// zero in every other field.
// Pipeline: the input register, then one compute stage (checks, length and TTL
// increment, checksum adder tree) feeding the result register; throughput is
// 1 transaction per cycle.
// Configuration: cfg_we writes cfg_data into the local (index 0) or remote
// (index 1) address; write only while no transaction is in flight.
// Reset (synchronous, rst_n low) clears both addresses and the pipeline valids.
// The receiver cannot stall; results are never held back.
module ipip_outer_header_builder
  import ipip_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [3:0]           in_inner_version,
  input  logic [7:0]           in_inner_protocol,
  input  logic [7:0]           in_inner_tos,
  input  logic [15:0]          in_inner_ident,
  input  logic [7:0]           in_inner_ttl,
  input  logic [31:0]          in_inner_source,
  input  logic [31:0]          in_inner_dest,
  input  logic [15:0]          in_inner_length,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  output logic                 out_strobe,
  output logic [2:0]           out_verdict,
  output logic [7:0]           out_tos,
  output logic [15:0]          out_length,
  output logic [15:0]          out_ident,
  output logic [7:0]           out_ttl,
  output logic [15:0]          out_checksum,
  output logic [31:0]          out_source,
  output logic [31:0]          out_dest
);

  logic [31:0] local_addr_r;
  logic [31:0] remote_addr_r;

  logic        in_valid_r;
  logic [3:0]  version_r;
  logic [7:0]  protocol_r;
  logic [7:0]  tos_r;
  logic [15:0] ident_r;
  logic [7:0]  ttl_r;
  logic [31:0] source_r;
  logic [31:0] dest_r;
  logic [15:0] length_r;

  verdict_t    verdict_nxt;
  hdr_fields_t hdr_nxt;
  logic [15:0] csum_nxt;

  logic        out_strobe_r;
  verdict_t    verdict_r;
  hdr_fields_t hdr_r;
  logic [15:0] csum_r;

  logic        accept;

  // every cycle can take a new transaction
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_addr_r  <= '0;
      remote_addr_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LOCAL_ADDR:  local_addr_r  <= cfg_data;
        CFG_REMOTE_ADDR: remote_addr_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      version_r  <= in_inner_version;
      protocol_r <= in_inner_protocol;
      tos_r      <= in_inner_tos;
      ident_r    <= in_inner_ident;
      ttl_r      <= in_inner_ttl;
      source_r   <= in_inner_source;
      dest_r     <= in_inner_dest;
      length_r   <= in_inner_length;
    end
  end

  // checks in priority order
  always_comb begin
    if (remote_addr_r == '0) begin
      verdict_nxt = VERDICT_NO_REMOTE;
    end else if (version_r != IP_V4) begin
      verdict_nxt = VERDICT_NOT_IPV4;
    end else if (protocol_r == PROTO_IPIP && source_r == local_addr_r) begin
      verdict_nxt = VERDICT_LOOP;
    end else if (dest_r == local_addr_r) begin
      verdict_nxt = VERDICT_INBOUND;
    end else begin
      verdict_nxt = VERDICT_FORWARD;
    end
  end

  // outer header fields
  always_comb begin
    hdr_nxt.tos    = tos_r;
    hdr_nxt.length = length_r + HDR_BYTES;
    hdr_nxt.ident  = ident_r;
    hdr_nxt.ttl    = ttl_r + 8'd1;
    hdr_nxt.source = local_addr_r;
    hdr_nxt.dest   = remote_addr_r;
  end

  ipip_csum u_csum (
    .hdr      (hdr_nxt),
    .checksum (csum_nxt)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid_r) begin
      verdict_r <= verdict_nxt;
      if (verdict_nxt == VERDICT_FORWARD) begin
        hdr_r  <= hdr_nxt;
        csum_r <= csum_nxt;
      end else begin
        hdr_r  <= '0;
        csum_r <= '0;
      end
    end
  end

  // result ports
  assign out_strobe   = out_strobe_r;
  assign out_verdict  = verdict_r;
  assign out_tos      = hdr_r.tos;
  assign out_length   = hdr_r.length;
  assign out_ident    = hdr_r.ident;
  assign out_ttl      = hdr_r.ttl;
  assign out_checksum = csum_r;
  assign out_source   = hdr_r.source;
  assign out_dest     = hdr_r.dest;

  // one result per accepted transaction, through the input and result registers
  a_strobe_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r |=> out_strobe)
    else $error("result strobe missing after accepted transaction");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(in_valid_r))
    else $error("result strobe without a transaction");

  // dropped results carry no header
  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_verdict != VERDICT_FORWARD) |->
      (out_length == '0 && out_checksum == '0 && out_source == '0 &&
       out_dest == '0 && out_ttl == '0))
    else $error("dropped result carries header fields");

  // forwarded results always have a remote end and an incremented ttl
  a_fwd_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_verdict == VERDICT_FORWARD) |->
      (out_dest != '0 && out_ttl == $past(ttl_r) + 8'd1))
    else $error("forwarded result has bad destination or ttl");

endmodule

/* tb/sv/ipip_outer_header_builder_tb.sv */
`timescale 1ns / 100ps

module ipip_outer_header_builder_tb;
  import ipip_pkg::*;

  localparam int STALL_LIMIT = 1000;
  localparam int RANDOM_PHASES = 7;
  localparam int ITEMS_PER_PHASE = 220;

  // one inner header as presented on the in_ ports
  typedef struct packed {
    logic [3:0]  version;
    logic [7:0]  protocol;
    logic [7:0]  tos;
    logic [15:0] ident;
    logic [7:0]  ttl;
    logic [31:0] source;
    logic [31:0] dest;
    logic [15:0] length;
  } inner_hdr_t;

  // one outer header result as seen on the out_ ports
  typedef struct packed {
    verdict_t    verdict;
    logic [7:0]  tos;
    logic [15:0] length;
    logic [15:0] ident;
    logic [7:0]  ttl;
    logic [15:0] checksum;
    logic [31:0] source;
    logic [31:0] dest;
  } outer_hdr_t;

  // tracks the tunnel addresses and the outer headers still owed by the block
  class tunnel_header_tracker;
    logic [31:0] local_addr;
    logic [31:0] remote_addr;
    outer_hdr_t  expected_outer[$];
    int          mismatches;

    function new();
      local_addr  = '0;
      remote_addr = '0;
      mismatches  = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
      case (idx)
        CFG_LOCAL_ADDR:  local_addr = data;
        CFG_REMOTE_ADDR: remote_addr = data;
        default: ;
      endcase
    endfunction

    // drop checks in priority order, then the outer header with its checksum
    function outer_hdr_t build_outer(inner_hdr_t h);
      outer_hdr_t  r;
      logic [31:0] sum;
      r = '0;
      if (remote_addr == '0) begin
        r.verdict = VERDICT_NO_REMOTE;
      end else if (h.version != IP_V4) begin
        r.verdict = VERDICT_NOT_IPV4;
      end else if (h.protocol == PROTO_IPIP && h.source == local_addr) begin
        r.verdict = VERDICT_LOOP;
      end else if (h.dest == local_addr) begin
        r.verdict = VERDICT_INBOUND;
      end else begin
        r.verdict  = VERDICT_FORWARD;
        r.tos      = h.tos;
        r.length   = h.length + HDR_BYTES;
        r.ident    = h.ident;
        r.ttl      = h.ttl + 8'd1;
        r.source   = local_addr;
        r.dest     = remote_addr;
        // fragment word and checksum word are zero during the sum
        sum = 32'({IP_V4, HDR_WORDS, r.tos}) + 32'(r.length) + 32'(r.ident)
            + 32'({r.ttl, PROTO_IPIP})
            + 32'(local_addr[31:16]) + 32'(local_addr[15:0])
            + 32'(remote_addr[31:16]) + 32'(remote_addr[15:0]);
        sum = 32'(sum[15:0]) + 32'(sum[31:16]);
        sum = 32'(sum[15:0]) + 32'(sum[31:16]);
        r.checksum = ~sum[15:0];
      end
      return r;
    endfunction

    function void note_inner(inner_hdr_t h);
      expected_outer.push_back(build_outer(h));
    endfunction

    function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
        mismatches++;
      end
    endfunction

    function void check_outer(outer_hdr_t got);
      outer_hdr_t exp_hdr;
      if (expected_outer.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, actual verdict %0h",
                 $time, got.verdict);
        mismatches++;
        return;
      end
      exp_hdr = expected_outer.pop_front();
      compare_field("verdict", exp_hdr.verdict, got.verdict);
      compare_field("tos", exp_hdr.tos, got.tos);
      compare_field("length", exp_hdr.length, got.length);
      compare_field("ident", exp_hdr.ident, got.ident);
      compare_field("ttl", exp_hdr.ttl, got.ttl);
      compare_field("checksum", exp_hdr.checksum, got.checksum);
      compare_field("source", exp_hdr.source, got.source);
      compare_field("dest", exp_hdr.dest, got.dest);
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [3:0]           in_inner_version = '0;
  logic [7:0]           in_inner_protocol = '0;
  logic [7:0]           in_inner_tos = '0;
  logic [15:0]          in_inner_ident = '0;
  logic [7:0]           in_inner_ttl = '0;
  logic [31:0]          in_inner_source = '0;
  logic [31:0]          in_inner_dest = '0;
  logic [15:0]          in_inner_length = '0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;
  logic                 out_strobe;
  logic [2:0]           out_verdict;
  logic [7:0]           out_tos;
  logic [15:0]          out_length;
  logic [15:0]          out_ident;
  logic [7:0]           out_ttl;
  logic [15:0]          out_checksum;
  logic [31:0]          out_source;
  logic [31:0]          out_dest;

  tunnel_header_tracker tracker = new();
  logic [31:0]          own_addr = '0;
  logic [31:0]          far_addr;
  bit                   quiet;
  int                   stall_cycles = 0;

  ipip_outer_header_builder dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_inner_version  (in_inner_version),
    .in_inner_protocol (in_inner_protocol),
    .in_inner_tos      (in_inner_tos),
    .in_inner_ident    (in_inner_ident),
    .in_inner_ttl      (in_inner_ttl),
    .in_inner_source   (in_inner_source),
    .in_inner_dest     (in_inner_dest),
    .in_inner_length   (in_inner_length),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_strobe        (out_strobe),
    .out_verdict       (out_verdict),
    .out_tos           (out_tos),
    .out_length        (out_length),
    .out_ident         (out_ident),
    .out_ttl           (out_ttl),
    .out_checksum      (out_checksum),
    .out_source        (out_source),
    .out_dest          (out_dest)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // monitor: record accepted headers, check results, watch for a hang
  always @(posedge clk) begin
    if (rst_n && start && busy === 1'b0) begin
      tracker.note_inner({in_inner_version, in_inner_protocol, in_inner_tos,
                          in_inner_ident, in_inner_ttl, in_inner_source,
                          in_inner_dest, in_inner_length});
    end
    if (rst_n && out_strobe === 1'b1) begin
      tracker.check_outer({verdict_t'(out_verdict), out_tos, out_length, out_ident,
                           out_ttl, out_checksum, out_source, out_dest});
    end
    if (rst_n && ((start && busy === 1'b0) || out_strobe === 1'b1)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic inner_hdr_t make_header(logic [3:0] ver, logic [7:0] proto,
                                             logic [7:0] tos, logic [15:0] ident,
                                             logic [7:0] ttl, logic [31:0] src,
                                             logic [31:0] dst, logic [15:0] len);
    inner_hdr_t h;
    h.version  = ver;
    h.protocol = proto;
    h.tos      = tos;
    h.ident    = ident;
    h.ttl      = ttl;
    h.source   = src;
    h.dest     = dst;
    h.length   = len;
    return h;
  endfunction

  // mostly valid ipv4 headers, with loop and inbound cases mixed in
  function automatic inner_hdr_t random_header(logic [31:0] addr);
    inner_hdr_t h;
    h.version  = ($urandom_range(0, 99) < 85) ? IP_V4 : 4'($urandom_range(0, 15));
    h.protocol = ($urandom_range(0, 99) < 30) ? PROTO_IPIP : 8'($urandom);
    h.tos      = 8'($urandom);
    h.ident    = 16'($urandom);
    h.ttl      = 8'($urandom);
    h.source   = ($urandom_range(0, 99) < 15) ? addr : 32'($urandom);
    h.dest     = ($urandom_range(0, 99) < 10) ? addr : 32'($urandom);
    h.length   = ($urandom_range(0, 99) < 90) ? 16'($urandom_range(20, 65515))
                                               : 16'($urandom);
    return h;
  endfunction

  // present one header and hold it until the block takes it
  task automatic send_header(inner_hdr_t h);
    in_inner_version  <= h.version;
    in_inner_protocol <= h.protocol;
    in_inner_tos      <= h.tos;
    in_inner_ident    <= h.ident;
    in_inner_ttl      <= h.ttl;
    in_inner_source   <= h.source;
    in_inner_dest     <= h.dest;
    in_inner_length   <= h.length;
    start             <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // stop sending and wait for every owed result
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (tracker.expected_outer.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // write both tunnel addresses; block must be idle
  task automatic set_tunnel(logic [31:0] local_v, logic [31:0] remote_v);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_LOCAL_ADDR;
    cfg_data  <= local_v;
    @(posedge clk);
    tracker.write_reg(CFG_LOCAL_ADDR, local_v);
    cfg_index <= CFG_REMOTE_ADDR;
    cfg_data  <= remote_v;
    @(posedge clk);
    tracker.write_reg(CFG_REMOTE_ADDR, remote_v);
    cfg_we   <= 1'b0;
    own_addr = local_v;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // no remote set after reset
    send_header(make_header(4'h0, 8'h00, 8'h00, 16'h0000, 8'h00, '0, '0, 16'h0000));
    send_header(make_header(4'hf, 8'hff, 8'hff, 16'hffff, 8'hff, '1, '1, 16'hffff));
    drain();

    // directed checks with a typical tunnel
    set_tunnel(32'h0a00_0001, 32'hc0a8_0002);
    send_header(make_header(IP_V4, 8'd6, 8'h00, 16'h1234, 8'd64,
                            32'hc0a8_0101, 32'h0808_0808, 16'd60));
    send_header(make_header(4'h0, 8'd6, 8'h10, 16'h0001, 8'd64,
                            32'hc0a8_0101, 32'h0808_0808, 16'd60));
    send_header(make_header(4'hf, 8'd6, 8'h10, 16'h0001, 8'd64,
                            32'hc0a8_0101, 32'h0808_0808, 16'd60));
    // routing loop, also when the dest is local
    send_header(make_header(IP_V4, PROTO_IPIP, 8'h00, 16'h0002, 8'd10,
                            32'h0a00_0001, 32'h0808_0808, 16'd100));
    send_header(make_header(IP_V4, PROTO_IPIP, 8'h00, 16'h0003, 8'd10,
                            32'h0a00_0001, 32'h0a00_0001, 16'd100));
    // version check wins over loop and inbound
    send_header(make_header(4'd6, PROTO_IPIP, 8'h00, 16'h0004, 8'd10,
                            32'h0a00_0001, 32'h0a00_0001, 16'd100));
    // ipip from elsewhere, and local source with another protocol
    send_header(make_header(IP_V4, PROTO_IPIP, 8'h22, 16'h0005, 8'd1,
                            32'h0a00_0002, 32'h0808_0808, 16'd40));
    send_header(make_header(IP_V4, 8'd41, 8'h22, 16'h0006, 8'd1,
                            32'h0a00_0001, 32'h0808_0808, 16'd40));
    // inbound
    send_header(make_header(IP_V4, 8'd17, 8'h00, 16'h0007, 8'd30,
                            32'h0101_0101, 32'h0a00_0001, 16'd28));
    // field extremes, ttl wrap, length wrap past the top
    send_header(make_header(IP_V4, 8'hff, 8'hff, 16'hffff, 8'hff,
                            32'hc0a8_0101, 32'h0808_0808, 16'd65515));
    send_header(make_header(IP_V4, 8'h00, 8'h00, 16'h0000, 8'h00,
                            32'h0000_0000, 32'h0808_0808, 16'd20));
    send_header(make_header(IP_V4, 8'd6, 8'h01, 16'h0008, 8'd5,
                            32'hc0a8_0101, 32'h0808_0808, 16'd65516));
    send_header(make_header(IP_V4, 8'd6, 8'h01, 16'h0009, 8'd5,
                            32'hc0a8_0101, 32'h0808_0808, 16'hffff));
    send_header(make_header(IP_V4, 8'd6, 8'h01, 16'h000a, 8'd5,
                            32'hc0a8_0101, 32'h0808_0808, 16'h0000));
    send_header(make_header(IP_V4, 8'd6, 8'hff, 16'hffff, 8'hfe,
                            32'hffff_ffff, 32'hffff_fffe, 16'hffeb));
    drain();

    // random phases over several tunnel settings
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: set_tunnel(32'h0000_0000, 32'hffff_ffff);
        1: set_tunnel(32'hffff_ffff, 32'h0000_0001);
        2: set_tunnel($urandom, 32'h0000_0000);
        default: begin
          far_addr = $urandom;
          if (far_addr == '0) far_addr = 32'h0000_0001;
          set_tunnel($urandom, far_addr);
        end
      endcase
      quiet = (p == 5);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_header(random_header(own_addr));
        if (!quiet && $urandom_range(0, 99) < 15) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 4)) @(posedge clk);
        end
      end
      drain();
    end

    if (tracker.mismatches == 0 && tracker.expected_outer.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/ipip_pkg.sv
hw/rtl/ipip_csum.sv
hw/rtl/ipip_outer_header_builder.sv
tb/sv/ipip_outer_header_builder_tb.sv
